// ===== sv/mxau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mxau_pkg
// shared types and constants of the 4x4 fixed-point matrix arithmetic unit
// ----------------------------------------------------------------------------
package mxau_pkg;

  localparam int unsigned MatDim   = 4;
  localparam int unsigned IdxW     = 2;                 // row / column index width
  localparam int unsigned CellW    = 2 * IdxW;          // flat element index width
  localparam int unsigned Cells    = MatDim * MatDim;
  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ProdW    = 2 * DataW;
  localparam int unsigned AccW     = 50;                // four truncated products, exact

  localparam logic [IdxW-1:0]  LastK    = IdxW'(MatDim - 1);
  localparam logic [CellW-1:0] LastCell = CellW'(Cells - 1);

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_COMPUTE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_MUL   = 2'd2,
    OP_SCALE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic            wr_en;   // load element pair
    logic            start;   // compute transaction accepted
    logic            rd_en;   // issue one operand read
    logic            first;   // first term of an element
    logic            last;    // last term of an element
    op_e             op;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic [IdxW-1:0] k;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic res_valid;          // result register loaded this cycle
  } status_t;

endpackage : mxau_pkg
`default_nettype wire

// ===== sv/matrix4x4_arith_unit.sv =====
`default_nettype none
// a load transaction writes one element pair; a compute transaction emits 16 results
// each result needs one operand read per product term (four for the matrix product, one for
//   add, subtract and scale), then passes 3 pipeline stages, and is held by out_ready_i;
//   the next element is not read until that result is taken
// reset: rst_ni is asynchronous, active low, and clears the sequencer and pipeline flags;
//   the matrix stores are not cleared and an entry reads as garbage until loaded
// ----------------------------------------------------------------------------
// matrix4x4_arith_unit
// 4x4 signed q16.16 matrix add, subtract, multiply and scale with saturation
// ----------------------------------------------------------------------------
module matrix4x4_arith_unit
  import mxau_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // input transaction channel
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    action_i,
  input  wire logic [IdxW-1:0]         row_i,
  input  wire logic [IdxW-1:0]         column_i,
  input  wire logic signed [DataW-1:0] a_value_i,
  input  wire logic signed [DataW-1:0] b_value_i,
  input  wire logic [1:0]              operation_i,
  input  wire logic signed [DataW-1:0] scale_factor_i,
  // result transaction channel
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [IdxW-1:0]              out_row_o,
  output logic [IdxW-1:0]              out_column_o,
  output logic signed [DataW-1:0]      out_value_o,
  output logic                         saturated_o,
  output logic                         last_o
);

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: accepts loads in idle, walks the 16 elements in row-major order,
  // issues one operand read per term (four for the product, one otherwise)
  // and holds each result until the result transaction completes
  mxau_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .operation_i  (operation_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_row_o    (out_row_o),
    .out_column_o (out_column_o),
    .last_o       (last_o),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  // datapath: two element stores, one 32x32 multiplier, add / subtract,
  // exact 50-bit accumulator, saturation into the result register
  mxau_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .a_value_i      (a_value_i),
    .b_value_i      (b_value_i),
    .scale_factor_i (scale_factor_i),
    .out_value_o    (out_value_o),
    .saturated_o    (saturated_o)
  );

endmodule : matrix4x4_arith_unit
`default_nettype wire

// ===== sv/mxau_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mxau_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module mxau_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : mxau_ram
`default_nettype wire

// ===== sv/mxau_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mxau_ctrl
// sequencer: load / compute handshakes, element and term counters
// ----------------------------------------------------------------------------
module mxau_ctrl
  import mxau_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            action_i,
  input  wire logic [IdxW-1:0] row_i,
  input  wire logic [IdxW-1:0] column_i,
  input  wire logic [1:0]      operation_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [IdxW-1:0]      out_row_o,
  output logic [IdxW-1:0]      out_column_o,
  output logic                 last_o,
  output cmd_t                 cmd_o,
  input  wire status_t         status_i
);

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [CellW-1:0] elem_q, elem_d;
  logic [IdxW-1:0]  k_q, k_d;
  logic             in_fire, out_fire, last_term;

  assign in_fire   = in_valid_i && (state_q == ST_IDLE);
  assign out_fire  = out_ready_i && (state_q == ST_OUT);
  assign last_term = (op_q == OP_MUL) ? (k_q == LastK) : (k_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (action_e'(action_i) == ACT_COMPUTE)) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (last_term) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (status_i.res_valid) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = (elem_q == LastCell) ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_d   = op_q;
    elem_d = elem_q;
    k_d    = k_q;

    cmd_o       = '0;
    cmd_o.op    = op_q;
    cmd_o.row   = elem_q[CellW-1:IdxW];
    cmd_o.col   = elem_q[IdxW-1:0];
    cmd_o.k     = k_q;
    cmd_o.first = (k_q == '0);
    cmd_o.last  = last_term;

    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);

    unique case (state_q)
      ST_IDLE: begin
        cmd_o.row = row_i;
        cmd_o.col = column_i;
        if (in_fire) begin
          if (action_e'(action_i) == ACT_LOAD) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            op_d        = op_e'(operation_i);
            elem_d      = '0;
            k_d         = '0;
          end
        end
      end
      ST_ISSUE: begin
        cmd_o.rd_en = 1'b1;
        k_d         = last_term ? '0 : k_q + 1'b1;
      end
      ST_WAIT: begin
      end
      ST_OUT: begin
        if (out_fire) begin
          elem_d = elem_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_row_o    = elem_q[CellW-1:IdxW];
  assign out_column_o = elem_q[IdxW-1:0];
  assign last_o       = (elem_q == LastCell);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_ADD;
      elem_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      elem_q  <= elem_d;
      k_q     <= k_d;
    end
  end

endmodule : mxau_ctrl
`default_nettype wire

// ===== sv/mxau_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mxau_dpath
// matrix storage, multiplier, adder, accumulator and saturating result register
// ----------------------------------------------------------------------------
module mxau_dpath
  import mxau_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cmd_t                    cmd_i,
  output status_t                      status_o,
  input  wire logic signed [DataW-1:0] a_value_i,
  input  wire logic signed [DataW-1:0] b_value_i,
  input  wire logic signed [DataW-1:0] scale_factor_i,
  output logic signed [DataW-1:0]      out_value_o,
  output logic                         saturated_o
);

  logic [CellW-1:0]         waddr, a_raddr, b_raddr;
  logic [DataW-1:0]         a_rd, b_rd;
  logic signed [DataW-1:0]  scale_q, mul_b;
  logic signed [ProdW-1:0]  prod_q, prod_d, prod_shift;
  logic signed [DataW:0]    addsub_q, addsub_d;
  logic signed [AccW-1:0]   term, acc_q, acc_d;
  logic signed [DataW-1:0]  value_q, value_d;
  logic                     sat_q, sat_d;
  logic                     s1_valid_q, s1_first_q, s1_last_q;
  logic                     s2_valid_q, s2_first_q, s2_last_q;
  logic                     s3_last_q;

  assign waddr   = {cmd_i.row, cmd_i.col};
  assign a_raddr = (cmd_i.op == OP_MUL) ? {cmd_i.row, cmd_i.k} : {cmd_i.row, cmd_i.col};
  assign b_raddr = (cmd_i.op == OP_MUL) ? {cmd_i.k, cmd_i.col} : {cmd_i.row, cmd_i.col};

  mxau_ram #(
    .Width (DataW),
    .Depth (Cells)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (a_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (a_raddr),
    .rdata_o (a_rd)
  );

  mxau_ram #(
    .Width (DataW),
    .Depth (Cells)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (b_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (b_raddr),
    .rdata_o (b_rd)
  );

  // stage 1: one product and one sum / difference
  always_comb begin
    mul_b  = (cmd_i.op == OP_SCALE) ? scale_q : $signed(b_rd);
    prod_d = $signed(a_rd) * mul_b;
    if (cmd_i.op == OP_SUB) begin
      addsub_d = {a_rd[DataW-1], a_rd} - {b_rd[DataW-1], b_rd};
    end else begin
      addsub_d = {a_rd[DataW-1], a_rd} + {b_rd[DataW-1], b_rd};
    end
  end

  // stage 2: truncate and accumulate
  always_comb begin
    prod_shift = prod_q >>> FracBits;
    if ((cmd_i.op == OP_ADD) || (cmd_i.op == OP_SUB)) begin
      term = {{(AccW-DataW-1){addsub_q[DataW]}}, addsub_q};
    end else begin
      term = prod_shift[AccW-1:0];
    end
    acc_d = s2_first_q ? term : acc_q + term;
  end

  // stage 3: saturate to 32 bits
  always_comb begin
    if (acc_q[AccW-1:DataW-1] == '0 || acc_q[AccW-1:DataW-1] == '1) begin
      value_d = acc_q[DataW-1:0];
      sat_d   = 1'b0;
    end else begin
      value_d = acc_q[AccW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
      sat_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      scale_q <= scale_factor_i;
    end
    if (s1_valid_q) begin
      prod_q   <= prod_d;
      addsub_q <= addsub_d;
    end
    if (s2_valid_q) begin
      acc_q <= acc_d;
    end
    if (s3_last_q) begin
      value_q <= value_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      s3_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.rd_en;
      s1_first_q <= cmd_i.first;
      s1_last_q  <= cmd_i.last;
      s2_valid_q <= s1_valid_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s3_last_q  <= s2_valid_q && s2_last_q;
    end
  end

  assign status_o.res_valid = s3_last_q;
  assign out_value_o        = value_q;
  assign saturated_o        = sat_q;

endmodule : mxau_dpath
`default_nettype wire

// ===== verif/mxau_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// mxau_tb_pkg
// result tracking for the matrix arithmetic unit bench: mirrors of both
// matrices, the queue of matrix elements still owed, and the field compare
// ----------------------------------------------------------------------------
package mxau_tb_pkg;
  import mxau_pkg::*;

  typedef struct {
    logic [IdxW-1:0]         row;
    logic [IdxW-1:0]         col;
    logic signed [DataW-1:0] value;
    logic                    sat;
    logic                    last;
  } elem_t;

  localparam longint SatHi = 64'sd2147483647;
  localparam longint SatLo = -SatHi - 64'sd1;

  class mx_scoreboard;
    logic signed [DataW-1:0] mat_a [Cells];
    logic signed [DataW-1:0] mat_b [Cells];
    elem_t                   owed_elems [$];
    int unsigned             errors  = 0;
    int unsigned             checked = 0;
    int unsigned             clipped = 0;
    int unsigned             loads   = 0;
    int unsigned             op_runs [4] = '{0, 0, 0, 0};

    // update the mirrors on a load, queue all 16 elements on a compute
    function void note_input(action_e act, logic [IdxW-1:0] row, logic [IdxW-1:0] col,
                             logic signed [DataW-1:0] av, logic signed [DataW-1:0] bv,
                             op_e op, logic signed [DataW-1:0] sf);
      int unsigned idx;
      int unsigned r;
      int unsigned c;
      int unsigned k;
      longint      acc;
      elem_t       e;
      if (act == ACT_LOAD) begin
        idx        = {row, col};
        mat_a[idx] = av;
        mat_b[idx] = bv;
        loads++;
        return;
      end
      op_runs[op]++;
      for (r = 0; r < MatDim; r++) begin
        for (c = 0; c < MatDim; c++) begin
          idx = r * MatDim + c;
          case (op)
            OP_ADD: acc = longint'(mat_a[idx]) + longint'(mat_b[idx]);
            OP_SUB: acc = longint'(mat_a[idx]) - longint'(mat_b[idx]);
            OP_MUL: begin
              // floor-shifted terms summed at full width, clipped once
              acc = 0;
              for (k = 0; k < MatDim; k++) begin
                acc += (longint'(mat_a[r * MatDim + k]) *
                        longint'(mat_b[k * MatDim + c])) >>> FracBits;
              end
            end
            default: acc = (longint'(mat_a[idx]) * longint'(sf)) >>> FracBits;
          endcase
          e.row  = IdxW'(r);
          e.col  = IdxW'(c);
          e.sat  = (acc > SatHi) || (acc < SatLo);
          e.last = (idx == Cells - 1);
          if (acc > SatHi) acc = SatHi;
          if (acc < SatLo) acc = SatLo;
          e.value = DataW'(acc);
          owed_elems.push_back(e);
        end
      end
    endfunction

    function void cmp_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [IdxW-1:0] row, logic [IdxW-1:0] col,
                               logic signed [DataW-1:0] value, logic sat, logic last);
      elem_t e;
      if (owed_elems.size() == 0) begin
        $error("unexpected result: row %0d col %0d value 0x%0h", row, col, value);
        errors++;
        return;
      end
      e = owed_elems.pop_front();
      checked++;
      if (e.sat) clipped++;
      cmp_field("out_row", DataW'(e.row), DataW'(row));
      cmp_field("out_column", DataW'(e.col), DataW'(col));
      cmp_field("out_value", e.value, value);
      cmp_field("saturated", DataW'(e.sat), DataW'(sat));
      cmp_field("last", DataW'(e.last), DataW'(last));
    endfunction

    function int unsigned outstanding();
      return owed_elems.size();
    endfunction
  endclass

endpackage : mxau_tb_pkg

// ===== verif/matrix4x4_arith_unit_test.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_arith_unit_test
// self-checking bench for the 4x4 q16.16 matrix unit: loads corner-value
// matrices and runs every operation, then random reload/compute bursts with
// random idling on both channels, a long output hold-off and a full drain
// ----------------------------------------------------------------------------
module matrix4x4_arith_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mxau_pkg::*;
  import mxau_tb_pkg::*;

  logic                    clk_i;
  logic                    rst_ni         = 1'b0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_ready_o;
  logic                    action_i       = ACT_LOAD;
  logic [IdxW-1:0]         row_i          = '0;
  logic [IdxW-1:0]         column_i       = '0;
  logic signed [DataW-1:0] a_value_i      = '0;
  logic signed [DataW-1:0] b_value_i      = '0;
  logic [1:0]              operation_i    = OP_ADD;
  logic signed [DataW-1:0] scale_factor_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i    = 1'b0;
  logic [IdxW-1:0]         out_row_o;
  logic [IdxW-1:0]         out_column_o;
  logic signed [DataW-1:0] out_value_o;
  logic                    saturated_o;
  logic                    last_o;

  mx_scoreboard sb = new;

  // knobs shared between the source and the sink, and the source's input count
  bit          calm     = 1'b0;   // no idling on either side while set
  bit          hold_ask = 1'b0;   // sink holds off for a long stretch
  int unsigned sent     = 0;      // accepted input transactions

  matrix4x4_arith_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .row_i          (row_i),
    .column_i       (column_i),
    .a_value_i      (a_value_i),
    .b_value_i      (b_value_i),
    .operation_i    (operation_i),
    .scale_factor_i (scale_factor_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_row_o      (out_row_o),
    .out_column_o   (out_column_o),
    .out_value_o    (out_value_o),
    .saturated_o    (saturated_o),
    .last_o         (last_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ------------------------------------------------------------------ source

  // random idle cycles after a transaction: a gap starts 37 times in 100 and goes on with the same odds
  task automatic source_gap();
    if (calm) return;
    if ($urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 37);
    end
  endtask

  // offer one transaction and hold it until the block takes it
  task automatic push_item(action_e act, logic [IdxW-1:0] row, logic [IdxW-1:0] col,
                           logic signed [DataW-1:0] av, logic signed [DataW-1:0] bv,
                           op_e op, logic signed [DataW-1:0] sf);
    in_valid_i     <= 1'b1;
    action_i       <= act;
    row_i          <= row;
    column_i       <= col;
    a_value_i      <= av;
    b_value_i      <= bv;
    operation_i    <= op;
    scale_factor_i <= sf;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(act, row, col, av, bv, op, sf);
    sent++;
    source_gap();
  endtask

  // load: operation and scale are don't-care, so they carry noise
  task automatic load_pair(logic [IdxW-1:0] row, logic [IdxW-1:0] col,
                           logic signed [DataW-1:0] av, logic signed [DataW-1:0] bv);
    push_item(ACT_LOAD, row, col, av, bv, op_e'($urandom_range(3)), $urandom());
  endtask

  // compute: index and element fields are don't-care, so they carry noise
  task automatic run_op(op_e op, logic signed [DataW-1:0] sf);
    push_item(ACT_COMPUTE, $urandom_range(3), $urandom_range(3), $urandom(), $urandom(),
              op, sf);
  endtask

  // stop offering until every owed element has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  function automatic logic signed [DataW-1:0] corner_value(int unsigned sel);
    case (sel % 8)
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return 32'shffff_ffff;    // smallest negative step
      4:       return 32'sh0000_0001;
      5:       return 32'sh0001_0000;    // +1.0
      6:       return 32'shffff_0000;    // -1.0
      default: return 32'sh0003_8000;    // +3.5
    endcase
  endfunction

  // mix of corners, full-range noise and small q16.16 numbers
  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0, 1:    return corner_value($urandom_range(7));
      2, 3, 4: return $urandom();
      default: return int'($urandom_range(524287)) - 262144;   // about +/- 4.0
    endcase
  endfunction

  // ------------------------------------------------------------------ sink

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(out_row_o, out_column_o, out_value_o, saturated_o, last_o);
      // long hold-off, counted here, so the block backs up into its input
      if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 37);
      end
    end
  end

  // ------------------------------------------------------------------ stimulus

  initial begin : stimulus
    int unsigned i;
    int unsigned burst;
    int unsigned nload;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every cell loaded with corners; first half pairs equal values,
    // second half pairs max with min, 0 with -1 and so on, so add and subtract
    // clip both ways and the product and scale overflow
    for (i = 0; i < Cells; i++) begin
      load_pair(IdxW'(i / MatDim), IdxW'(i % MatDim), corner_value(i),
                corner_value(i < 8 ? i : i ^ 1));
    end
    run_op(OP_ADD, $urandom());
    run_op(OP_SUB, $urandom());
    run_op(OP_MUL, $urandom());
    run_op(OP_SCALE, 32'sh7fff_ffff);
    run_op(OP_SCALE, 32'sh8000_0000);
    run_op(OP_SCALE, 32'sh0001_0000);
    run_op(OP_SCALE, 32'shffff_ffff);
    drain();

    // random: bursts of reloads followed by one or two computes, with three more in burst 12
    burst = 0;
    while (sent < 525) begin
      burst++;
      calm = (burst >= 30 && burst < 38);
      if ($urandom_range(9) == 0) begin
        for (i = 0; i < Cells; i++)
          load_pair(IdxW'(i / MatDim), IdxW'(i % MatDim), pick_value(), pick_value());
      end else begin
        nload = $urandom_range(16, 1);
        repeat (nload)
          load_pair($urandom_range(3), $urandom_range(3), pick_value(), pick_value());
      end
      if (burst == 12) begin
        // sink stalls while computes keep coming
        hold_ask = 1'b1;
        repeat (3) run_op(op_e'($urandom_range(3)), pick_value());
      end
      repeat ($urandom_range(2, 1)) run_op(op_e'($urandom_range(3)), pick_value());
      if (burst == 22) drain();
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("covered %0d transactions: %0d loads, %0d computes (add %0d sub %0d mul %0d scale %0d)",
             sent, sb.loads, sent - sb.loads, sb.op_runs[OP_ADD], sb.op_runs[OP_SUB],
             sb.op_runs[OP_MUL], sb.op_runs[OP_SCALE]);
    $display("checked %0d result elements, %0d clipped, %0d mismatches",
             sb.checked, sb.clipped, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule : matrix4x4_arith_unit_test
